[rtl/core/quadratic_root_and_vertex_solver_core_macros.svh]
// Assertion macros for the quadratic solver core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef QUADRATIC_ROOT_AND_VERTEX_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_AND_VERTEX_SOLVER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define QRV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qrv assertion failed");
// next-cycle implication
`define QRV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qrv assertion failed");
`else
`define QRV_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define QRV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/qrv_pkg.sv]
// Shared types, constants and helpers of the quadratic solver core.
// No dependencies.
`default_nettype none

package qrv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = 32;
  localparam int QUO_W     = OUT_W + FRAC_BITS;  // quotient width of b/2a and c/a
  localparam int XV_W      = QUO_W + 1;          // signed -p/2 before saturation
  localparam int WIDE_W    = 96;                 // exact sums and discriminant
  localparam int SQ_W      = WIDE_W / 2;         // square root width

  localparam logic [OUT_W-1:0] WORD_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] WORD_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_A_ZERO   = 2'd3
  } root_kind_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] coef_a;
    logic signed [OUT_W-1:0] coef_b;
    logic signed [OUT_W-1:0] coef_c;
  } qrv_in_t;

  typedef struct packed {
    root_kind_t              root_kind;
    logic signed [OUT_W-1:0] root_first;
    logic signed [OUT_W-1:0] root_second;
    logic signed [OUT_W-1:0] vertex_x;
    logic signed [OUT_W-1:0] vertex_y;
    logic                    is_maximum;
    logic                    overflowed;
  } qrv_out_t;

  typedef struct packed {
    logic             ovf;
    logic [OUT_W-1:0] val;
  } sat_t;

  // clamp a two's complement wide value to one output word
  function automatic sat_t sat_word(input logic [WIDE_W-1:0] v);
    sat_t r;
    logic all_ones;
    logic all_zeros;
    all_ones  = &v[WIDE_W-1:OUT_W-1];
    all_zeros = ~|v[WIDE_W-1:OUT_W-1];
    r.ovf = !(all_ones || all_zeros);
    if (r.ovf) begin
      r.val = v[WIDE_W-1] ? WORD_MIN : WORD_MAX;
    end else begin
      r.val = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/quadratic_root_and_vertex_solver_core.sv]
// Quadratic root and vertex solver, signed Q16.16. Takes a, b, c and returns
// the root class, both roots (or real part and imaginary magnitude), the
// vertex x = -b/2a, y at the vertex, a maximum flag and a saturation flag.
// One coefficient set is taken every clock while coef_stall is low. Stages
// are input, the 48-stage divider (b/2a and c/a, one quotient bit per stage),
// six arithmetic, the 48-stage square root (one root bit per stage), final
// and output register stages. A one-entry skid behind the output register
// holds one more finished result while the output is stalled; the pipeline
// stalls while it is full. Uses qrv_pkg, qrv_div_pipe, qrv_sqrt_pipe and
// qrv_out_buf.
`default_nettype none

module quadratic_root_and_vertex_solver_core
  import qrv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     coef_valid,
  output logic     coef_stall,
  input  qrv_in_t  coef,
  output logic     result_valid,
  input  logic     result_stall,
  output qrv_out_t result
);

  typedef struct packed {
    root_kind_t       kind;
    logic [XV_W-1:0]  xv;
    logic [OUT_W-1:0] vx;
    logic [OUT_W-1:0] vy;
    logic             ovf;
    logic             a_neg;
  } sq_side_t;

  localparam int HALF = QUO_W / 2;

  logic en;
  assign coef_stall = !en;

  // input stage
  logic    s0_v;
  qrv_in_t s0_co;
  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (en) s0_v <= coef_valid;
  end
  always_ff @(posedge clk) begin
    if (en) s0_co <= coef;
  end

  // magnitudes feed the divider
  logic [OUT_W-1:0] s0_am, s0_bm, s0_cm;
  assign s0_am = s0_co.coef_a[OUT_W-1] ? (~s0_co.coef_a + 1'b1) : s0_co.coef_a;
  assign s0_bm = s0_co.coef_b[OUT_W-1] ? (~s0_co.coef_b + 1'b1) : s0_co.coef_b;
  assign s0_cm = s0_co.coef_c[OUT_W-1] ? (~s0_co.coef_c + 1'b1) : s0_co.coef_c;

  logic             dv_v;
  logic [QUO_W-1:0] dv_hm, dv_qm;
  qrv_in_t          dv_co;

  qrv_div_pipe #(
    .NUM_W  (QUO_W),
    .DEN_W  (OUT_W + 1),
    .SIDE_W ($bits(qrv_in_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s0_v),
    .num0     ({s0_bm, {FRAC_BITS{1'b0}}}),
    .den0     ({s0_am, 1'b0}),
    .num1     ({s0_cm, {FRAC_BITS{1'b0}}}),
    .den1     ({1'b0, s0_am}),
    .side_in  (s0_co),
    .out_valid(dv_v),
    .quo0     (dv_hm),
    .quo1     (dv_qm),
    .side_out (dv_co)
  );

  // E1: signed vertex x, its saturation, partial products of h^2
  logic             e1_v;
  logic [QUO_W-1:0] e1_hm, e1_qm;
  qrv_in_t          e1_co;
  always_ff @(posedge clk) begin
    if (rst) e1_v <= 1'b0;
    else if (en) e1_v <= dv_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e1_hm <= dv_hm;
      e1_qm <= dv_qm;
      e1_co <= dv_co;
    end
  end

  logic [XV_W-1:0]   e1_xv;
  sat_t              e1_vx;
  logic [2*HALF-1:0] e1_pll, e1_plh, e1_phh;
  always_comb begin
    if (e1_co.coef_b[OUT_W-1] == e1_co.coef_a[OUT_W-1]) begin
      e1_xv = XV_W'(0) - {1'b0, e1_hm};
    end else begin
      e1_xv = {1'b0, e1_hm};
    end
    e1_vx  = sat_word({{(WIDE_W-XV_W){e1_xv[XV_W-1]}}, e1_xv});
    e1_pll = (2*HALF)'(e1_hm[HALF-1:0]) * (2*HALF)'(e1_hm[HALF-1:0]);
    e1_plh = (2*HALF)'(e1_hm[HALF-1:0]) * (2*HALF)'(e1_hm[QUO_W-1:HALF]);
    e1_phh = (2*HALF)'(e1_hm[QUO_W-1:HALF]) * (2*HALF)'(e1_hm[QUO_W-1:HALF]);
  end

  // E2: assemble h^2, square |x|, form b*x
  logic              e2_v;
  logic [2*HALF-1:0] e2_pll, e2_plh, e2_phh;
  logic [QUO_W-1:0]  e2_qm;
  logic [XV_W-1:0]   e2_xv;
  logic signed [OUT_W-1:0] e2_vx;
  logic              e2_ovf;
  qrv_in_t           e2_co;
  always_ff @(posedge clk) begin
    if (rst) e2_v <= 1'b0;
    else if (en) e2_v <= e1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e2_pll <= e1_pll;
      e2_plh <= e1_plh;
      e2_phh <= e1_phh;
      e2_qm  <= e1_qm;
      e2_xv  <= e1_xv;
      e2_vx  <= e1_vx.val;
      e2_ovf <= e1_vx.ovf;
      e2_co  <= e1_co;
    end
  end

  logic [WIDE_W-1:0]       e2_h2;
  logic [OUT_W-1:0]        e2_xm;
  logic [2*OUT_W-1:0]      e2_xm2;
  logic signed [2*OUT_W-1:0] e2_bvx;
  always_comb begin
    e2_h2  = (WIDE_W'(e2_phh) << (2*HALF)) + (WIDE_W'(e2_plh) << (HALF+1))
           + WIDE_W'(e2_pll);
    e2_xm  = e2_vx[OUT_W-1] ? (~e2_vx + 1'b1) : e2_vx;
    e2_xm2 = (2*OUT_W)'(e2_xm) * (2*OUT_W)'(e2_xm);
    e2_bvx = (2*OUT_W)'(e2_co.coef_b) * (2*OUT_W)'(e2_vx);
  end

  // E3: discriminant and root class; |a| times x^2 in two halves
  logic                 e3_v;
  logic [WIDE_W-1:0]    e3_h2;
  logic [QUO_W-1:0]     e3_qm;
  logic [XV_W-1:0]      e3_xv;
  logic [OUT_W-1:0]     e3_vx;
  logic                 e3_ovf;
  logic [2*OUT_W-2:0]   e3_xm2;
  logic [2*OUT_W-1:0]   e3_bvx;
  qrv_in_t              e3_co;
  always_ff @(posedge clk) begin
    if (rst) e3_v <= 1'b0;
    else if (en) e3_v <= e2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e3_h2  <= e2_h2;
      e3_qm  <= e2_qm;
      e3_xv  <= e2_xv;
      e3_vx  <= e2_vx;
      e3_ovf <= e2_ovf;
      e3_xm2 <= e2_xm2[2*OUT_W-2:0];
      e3_bvx <= e2_bvx;
      e3_co  <= e2_co;
    end
  end

  logic [WIDE_W-1:0]  e3_qs, e3_sum, e3_dqh, e3_dm;
  logic [WIDE_W:0]    e3_dhq;
  logic               e3_qneg;
  root_kind_t         e3_kind;
  logic [OUT_W-1:0]   e3_am;
  logic [2*OUT_W-1:0] e3_pl, e3_ph;
  always_comb begin
    e3_qs   = WIDE_W'({e3_qm, {FRAC_BITS{1'b0}}});
    e3_qneg = e3_co.coef_c[OUT_W-1] != e3_co.coef_a[OUT_W-1];
    e3_sum  = e3_h2 + e3_qs;
    e3_dhq  = {1'b0, e3_h2} - {1'b0, e3_qs};
    e3_dqh  = e3_qs - e3_h2;
    if (e3_co.coef_a == '0) begin
      e3_kind = KIND_A_ZERO;
      e3_dm   = '0;
    end else if (e3_qneg) begin
      e3_kind = (e3_sum == '0) ? KIND_DOUBLE : KIND_TWO_REAL;
      e3_dm   = e3_sum;
    end else if (e3_dhq[WIDE_W]) begin
      e3_kind = KIND_COMPLEX;
      e3_dm   = e3_dqh;
    end else if (e3_dhq == '0) begin
      e3_kind = KIND_DOUBLE;
      e3_dm   = '0;
    end else begin
      e3_kind = KIND_TWO_REAL;
      e3_dm   = e3_dhq[WIDE_W-1:0];
    end
    e3_am = e3_co.coef_a[OUT_W-1] ? (~e3_co.coef_a + 1'b1) : e3_co.coef_a;
    e3_pl = (2*OUT_W)'(e3_am) * (2*OUT_W)'(e3_xm2[OUT_W-1:0]);
    e3_ph = (2*OUT_W)'(e3_am) * (2*OUT_W)'(e3_xm2[2*OUT_W-2:OUT_W]);
  end

  // E4: combine the halves of a*x^2
  logic               e4_v;
  logic [WIDE_W-1:0]  e4_dm;
  root_kind_t         e4_kind;
  logic [XV_W-1:0]    e4_xv;
  logic [OUT_W-1:0]   e4_vx;
  logic               e4_ovf;
  logic [2*OUT_W-1:0] e4_pl, e4_ph, e4_bvx;
  qrv_in_t            e4_co;
  always_ff @(posedge clk) begin
    if (rst) e4_v <= 1'b0;
    else if (en) e4_v <= e3_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e4_dm   <= e3_dm;
      e4_kind <= e3_kind;
      e4_xv   <= e3_xv;
      e4_vx   <= e3_vx;
      e4_ovf  <= e3_ovf;
      e4_pl   <= e3_pl;
      e4_ph   <= e3_ph;
      e4_bvx  <= e3_bvx;
      e4_co   <= e3_co;
    end
  end

  logic [WIDE_W-1:0] e4_t1m;
  assign e4_t1m = (WIDE_W'(e4_ph) << OUT_W) + WIDE_W'(e4_pl);

  // E5: signed a*x^2 plus b*x, aligned to 3*FRAC_BITS
  logic               e5_v;
  logic [WIDE_W-1:0]  e5_dm, e5_t1m;
  root_kind_t         e5_kind;
  logic [XV_W-1:0]    e5_xv;
  logic [OUT_W-1:0]   e5_vx;
  logic               e5_ovf;
  logic [2*OUT_W-1:0] e5_bvx;
  qrv_in_t            e5_co;
  always_ff @(posedge clk) begin
    if (rst) e5_v <= 1'b0;
    else if (en) e5_v <= e4_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e5_dm   <= e4_dm;
      e5_t1m  <= e4_t1m;
      e5_kind <= e4_kind;
      e5_xv   <= e4_xv;
      e5_vx   <= e4_vx;
      e5_ovf  <= e4_ovf;
      e5_bvx  <= e4_bvx;
      e5_co   <= e4_co;
    end
  end

  logic [WIDE_W-1:0] e5_t2, e5_s12;
  always_comb begin
    e5_t2  = {{(WIDE_W-2*OUT_W-FRAC_BITS){e5_bvx[2*OUT_W-1]}}, e5_bvx,
              {FRAC_BITS{1'b0}}};
    e5_s12 = e5_co.coef_a[OUT_W-1] ? (e5_t2 - e5_t1m) : (e5_t2 + e5_t1m);
  end

  // E6: add c, floor to FRAC_BITS, saturate vertex y
  logic              e6_v;
  logic [WIDE_W-1:0] e6_dm, e6_s12;
  root_kind_t        e6_kind;
  logic [XV_W-1:0]   e6_xv;
  logic [OUT_W-1:0]  e6_vx;
  logic              e6_ovf;
  qrv_in_t           e6_co;
  always_ff @(posedge clk) begin
    if (rst) e6_v <= 1'b0;
    else if (en) e6_v <= e5_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e6_dm   <= e5_dm;
      e6_s12  <= e5_s12;
      e6_kind <= e5_kind;
      e6_xv   <= e5_xv;
      e6_vx   <= e5_vx;
      e6_ovf  <= e5_ovf;
      e6_co   <= e5_co;
    end
  end

  logic [WIDE_W-1:0] e6_t3, e6_sum;
  sat_t              e6_vy;
  sq_side_t          e6_side;
  always_comb begin
    e6_t3  = {{(WIDE_W-OUT_W-2*FRAC_BITS){e6_co.coef_c[OUT_W-1]}}, e6_co.coef_c,
              {(2*FRAC_BITS){1'b0}}};
    e6_sum = e6_s12 + e6_t3;
    e6_vy  = sat_word({{(2*FRAC_BITS){e6_sum[WIDE_W-1]}},
                       e6_sum[WIDE_W-1:2*FRAC_BITS]});
    e6_side.kind  = e6_kind;
    e6_side.xv    = e6_xv;
    e6_side.vx    = e6_vx;
    e6_side.vy    = e6_vy.val;
    e6_side.ovf   = e6_ovf || e6_vy.ovf;
    e6_side.a_neg = e6_co.coef_a[OUT_W-1];
  end

  logic            sq_v;
  logic [SQ_W-1:0] sq_root;
  sq_side_t        sq_side;

  qrv_sqrt_pipe #(
    .D_W    (WIDE_W),
    .SIDE_W ($bits(sq_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (e6_v),
    .radicand (e6_dm),
    .side_in  (e6_side),
    .out_valid(sq_v),
    .root     (sq_root),
    .side_out (sq_side)
  );

  // final: roots from -h -+ sqrt, saturate, pack the result
  logic [XV_W:0] fx, fs, fd1, fd2;
  sat_t          fr1, fr2;
  qrv_out_t      f_next;
  always_comb begin
    fx  = {sq_side.xv[XV_W-1], sq_side.xv};
    fs  = (XV_W+1)'(sq_root);
    fd1 = fx - fs;
    fd2 = fx + fs;
    if (sq_side.kind == KIND_COMPLEX) begin
      fr1 = sat_word({{(WIDE_W-XV_W-1){fx[XV_W]}}, fx});
      fr2 = sat_word(WIDE_W'(sq_root));
    end else begin
      fr1 = sat_word({{(WIDE_W-XV_W-1){fd1[XV_W]}}, fd1});
      fr2 = sat_word({{(WIDE_W-XV_W-1){fd2[XV_W]}}, fd2});
    end
    if (sq_side.kind == KIND_A_ZERO) begin
      f_next           = '0;
      f_next.root_kind = KIND_A_ZERO;
    end else begin
      f_next.root_kind   = sq_side.kind;
      f_next.root_first  = fr1.val;
      f_next.root_second = fr2.val;
      f_next.vertex_x    = sq_side.vx;
      f_next.vertex_y    = sq_side.vy;
      f_next.is_maximum  = sq_side.a_neg;
      f_next.overflowed  = sq_side.ovf || fr1.ovf || fr2.ovf;
    end
  end

  logic     f_v;
  qrv_out_t f_res;
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= sq_v;
  end
  always_ff @(posedge clk) begin
    if (en) f_res <= f_next;
  end

  qrv_out_buf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_v),
    .in_data  (f_res),
    .en       (en),
    .out_valid(result_valid),
    .out_stall(result_stall),
    .out_data (result)
  );

endmodule

`default_nettype wire

[rtl/core/qrv_div_pipe.sv]
// Two-lane restoring divider, one quotient bit per pipeline stage.
// Stand-alone; side data rides along with each item.
`default_nettype none

module qrv_div_pipe #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 33,
  parameter int SIDE_W = 96
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num0,
  input  logic [DEN_W-1:0]  den0,
  input  logic [NUM_W-1:0]  num1,
  input  logic [DEN_W-1:0]  den1,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo0,
  output logic [NUM_W-1:0]  quo1,
  output logic [SIDE_W-1:0] side_out
);

  localparam int REM_W = DEN_W + 1;
  localparam int ACC_W = REM_W + NUM_W;

  // shift in one dividend bit, subtract when the partial remainder allows
  function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                input logic [DEN_W-1:0] den);
    logic [ACC_W-1:0] sh;
    logic [REM_W-1:0] trial;
    sh    = acc << 1;
    trial = sh[ACC_W-1 -: REM_W];
    if (trial >= {1'b0, den}) begin
      sh[ACC_W-1 -: REM_W] = trial - {1'b0, den};
      sh[0] = 1'b1;
    end
    return sh;
  endfunction

  logic [ACC_W-1:0]  acc0 [NUM_W];
  logic [ACC_W-1:0]  acc1 [NUM_W];
  logic [DEN_W-1:0]  dr0  [NUM_W];
  logic [DEN_W-1:0]  dr1  [NUM_W];
  logic [SIDE_W-1:0] side [NUM_W];
  logic              vld  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [ACC_W-1:0]  src0, src1;
    logic [DEN_W-1:0]  sden0, sden1;
    logic [SIDE_W-1:0] sside;
    logic              svld;

    if (k == 0) begin : g_first
      assign src0  = {{REM_W{1'b0}}, num0};
      assign src1  = {{REM_W{1'b0}}, num1};
      assign sden0 = den0;
      assign sden1 = den1;
      assign sside = side_in;
      assign svld  = in_valid;
    end else begin : g_rest
      assign src0  = acc0[k-1];
      assign src1  = acc1[k-1];
      assign sden0 = dr0[k-1];
      assign sden1 = dr1[k-1];
      assign sside = side[k-1];
      assign svld  = vld[k-1];
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= svld;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        acc0[k] <= div_step(src0, sden0);
        acc1[k] <= div_step(src1, sden1);
        dr0[k]  <= sden0;
        dr1[k]  <= sden1;
        side[k] <= sside;
      end
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quo0      = acc0[NUM_W-1][NUM_W-1:0];
  assign quo1      = acc1[NUM_W-1][NUM_W-1:0];
  assign side_out  = side[NUM_W-1];

endmodule

`default_nettype wire

[rtl/core/qrv_sqrt_pipe.sv]
// Digit-by-digit integer square root (floor), one root bit per stage.
// Stand-alone; side data rides along with each item.
`default_nettype none

module qrv_sqrt_pipe #(
  parameter int D_W    = 96,
  parameter int SIDE_W = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [D_W-1:0]    radicand,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [D_W/2-1:0]  root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int RES_W = D_W / 2;
  localparam int REM_W = RES_W + 3;

  logic [REM_W-1:0]  rem  [RES_W];
  logic [RES_W-1:0]  rt   [RES_W];
  logic [D_W-1:0]    dsh  [RES_W];
  logic [SIDE_W-1:0] side [RES_W];
  logic              vld  [RES_W];

  for (genvar k = 0; k < RES_W; k++) begin : g_stage
    logic [REM_W-1:0]  srem, cur, trial, rem_next;
    logic [RES_W-1:0]  sroot, root_next;
    logic [D_W-1:0]    sd;
    logic [SIDE_W-1:0] sside;
    logic              svld;

    if (k == 0) begin : g_first
      assign srem  = '0;
      assign sroot = '0;
      assign sd    = radicand;
      assign sside = side_in;
      assign svld  = in_valid;
    end else begin : g_rest
      assign srem  = rem[k-1];
      assign sroot = rt[k-1];
      assign sd    = dsh[k-1];
      assign sside = side[k-1];
      assign svld  = vld[k-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      cur   = {srem[REM_W-3:0], sd[D_W-1 -: 2]};
      trial = REM_W'({sroot, 2'b01});
      if (cur >= trial) begin
        rem_next  = cur - trial;
        root_next = {sroot[RES_W-2:0], 1'b1};
      end else begin
        rem_next  = cur;
        root_next = {sroot[RES_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= svld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= rem_next;
        rt[k]   <= root_next;
        dsh[k]  <= sd << 2;
        side[k] <= sside;
      end
    end
  end

  assign out_valid = vld[RES_W-1];
  assign root      = rt[RES_W-1];
  assign side_out  = side[RES_W-1];

endmodule

`default_nettype wire

[rtl/core/qrv_out_buf.sv]
// Output register with one skid entry; the pipeline stalls only while it is full.
// Depends on qrv_pkg and the assertion macro header.
`default_nettype none
`include "quadratic_root_and_vertex_solver_core_macros.svh"

module qrv_out_buf
  import qrv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  qrv_out_t in_data,
  output logic     en,
  output logic     out_valid,
  input  logic     out_stall,
  output qrv_out_t out_data
);

  logic     skid_v;
  qrv_out_t skid_data;
  logic     take;
  logic     drain;

  // pipeline moves whenever the skid entry is free
  assign en    = !skid_v;
  assign take  = in_valid && en;
  assign drain = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (drain) begin
      out_valid <= skid_v || take;
      skid_v    <= 1'b0;
    end else if (take) begin
      skid_v    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data <= skid_v ? skid_data : in_data;
    end else if (take) begin
      skid_data <= in_data;
    end
  end

  `QRV_ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_v, out_valid)
  `QRV_ASSERT_IMPLIES(a_skid_fill_on_stall, clk, rst, $rose(skid_v), $past(out_valid && out_stall))
  `QRV_ASSERT_NEXT(a_skid_drains, clk, rst, skid_v && !out_stall, out_valid && out_data == $past(skid_data))

endmodule

`default_nettype wire

[tb/quadratic_root_and_vertex_solver_core_test.sv]
// Testbench for the quadratic root and vertex solver core: drives coefficient
// sets through the valid/stall channel and compares each result with a local
// fixed-point predictor. Depends on qrv_pkg and the core RTL.
`default_nettype none

module quadratic_root_and_vertex_solver_core_test;
  import qrv_pkg::*;

  localparam int LATENCY = 105;
  localparam longint CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     coef_valid = 1'b0;
  logic     coef_stall;
  qrv_in_t  coef = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  qrv_out_t result;

  qrv_out_t solutions_due[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       sets_sent = 0;
  int       complex_seen = 0;
  int       saturated_seen = 0;
  longint   cycle = 0;
  bit       stall_free = 1'b0;

  quadratic_root_and_vertex_solver_core uut (
    .clk(clk), .rst(rst),
    .coef_valid(coef_valid), .coef_stall(coef_stall), .coef(coef),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #10 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // clamp a wide signed value to one output word
  function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v,
                                                    inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // floor square root of a non-negative 128-bit value
  function automatic logic [63:0] floor_sqrt(input logic [127:0] d);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= d) r = t;
    end
    return r;
  endfunction

  // expected solution for one coefficient set
  function automatic qrv_out_t solve_quadratic(input qrv_in_t s);
    qrv_out_t o;
    logic signed [127:0] a, b, c, xv, r1, r2, vx, sum;
    logic [127:0] am, bm, cm, hm, qm, h2, qs, disc;
    logic [63:0] rt;
    logic qneg, ovf;
    root_kind_t kind;
    o = '0;
    if (s.coef_a == 0) begin
      o.root_kind = KIND_A_ZERO;
      return o;
    end
    a = s.coef_a; b = s.coef_b; c = s.coef_c;
    am = a < 0 ? -a : a;
    bm = b < 0 ? -b : b;
    cm = c < 0 ? -c : c;
    hm = (bm << FRAC_BITS) / (2 * am);
    qm = (cm << FRAC_BITS) / am;
    xv = ((b < 0) == (a < 0)) ? -$signed(hm) : $signed(hm);
    qneg = (c < 0) != (a < 0);
    h2 = hm * hm;
    qs = qm << FRAC_BITS;
    if (qneg) begin
      disc = h2 + qs;
      kind = disc == 0 ? KIND_DOUBLE : KIND_TWO_REAL;
    end else if (h2 > qs) begin
      kind = KIND_TWO_REAL; disc = h2 - qs;
    end else if (h2 == qs) begin
      kind = KIND_DOUBLE; disc = 0;
    end else begin
      kind = KIND_COMPLEX; disc = qs - h2;
    end
    rt = floor_sqrt(disc);
    if (kind == KIND_COMPLEX) begin
      r1 = xv; r2 = $signed({64'd0, rt});
    end else begin
      r1 = xv - $signed({64'd0, rt}); r2 = xv + $signed({64'd0, rt});
    end
    ovf = 1'b0;
    o.root_kind   = kind;
    o.root_first  = clamp_word(r1, ovf);
    o.root_second = clamp_word(r2, ovf);
    o.vertex_x    = clamp_word(xv, ovf);
    vx = o.vertex_x;
    sum = a * vx * vx + ((b * vx) <<< FRAC_BITS) + (c <<< (2 * FRAC_BITS));
    o.vertex_y    = clamp_word(sum >>> (2 * FRAC_BITS), ovf);
    o.is_maximum  = s.coef_a < 0;
    o.overflowed  = ovf;
    return o;
  endfunction

  // receiver: own stall pattern, check every transfer out
  always @(posedge clk) begin
    qrv_out_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (result.root_kind == KIND_COMPLEX) complex_seen++;
        if (result.overflowed) saturated_seen++;
        if (solutions_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result);
        end else begin
          want = solutions_due.pop_front();
          if (result.root_kind !== want.root_kind ||
              result.root_first !== want.root_first ||
              result.root_second !== want.root_second ||
              result.vertex_x !== want.vertex_x ||
              result.vertex_y !== want.vertex_y ||
              result.is_maximum !== want.is_maximum ||
              result.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", want, result);
          end
        end
      end
      if (stall_free) result_stall <= 1'b0;
      else result_stall <= (cycle % 64 < 16) ? ($urandom_range(0, 3) == 0)
                                            : ($urandom_range(0, 2) == 0);
    end
  end

  int burst_left = 0;

  // send one coefficient set, with bursts and gaps
  task automatic send_set(input qrv_in_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      // drop valid only when a real gap follows
      if (gap > 0) begin
        coef_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    coef_valid <= 1'b1;
    coef <= s;
    @(posedge clk);
    while (coef_stall) @(posedge clk);
    solutions_due.push_back(solve_quadratic(s));
    sets_sent++;
  endtask

  task automatic idle_until_drained();
    coef_valid <= 1'b0;
    while (solutions_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'h00000001;
      4: return 32'hffffffff;
      default: return 32'h00010000;
    endcase
  endfunction

  // corners, zero a, double, complex, saturation
  task automatic test_directed();
    send_set('{32'sh0, 32'sh10000, 32'sh10000});
    send_set('{32'sh10000, 32'sh0, -32'sh10000});
    send_set('{32'sh10000, 32'sh20000, 32'sh10000});
    send_set('{32'sh10000, 32'sh0, 32'sh10000});
    send_set('{-32'sh10000, 32'sh30000, -32'sh20000});
    send_set('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    send_set('{32'sh80000000, 32'sh80000000, 32'sh80000000});
    send_set('{32'sh1, 32'sh7fffffff, 32'sh80000000});
    send_set('{32'sh80000000, 32'sh1, 32'sh7fffffff});
    send_set('{32'shffffffff, 32'sh0, 32'sh0});
    send_set('{32'sh1, 32'sh80000000, 32'sh7fffffff});
    send_set('{32'sh1, 32'sh0, 32'sh0});
    send_set('{32'sh10000, 32'sh7fffffff, 32'sh0});
    send_set('{32'sh20000, -32'sh40000, 32'sh20000});
    for (int i = 0; i < 8; i++) send_set('{edge_word(), edge_word(), edge_word()});
  endtask

  // random sets: half moderate, the rest full range or with edge words
  task automatic test_random(input int count);
    qrv_in_t s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: s = '{$urandom, $urandom, $urandom};
        1: s = '{edge_word(), $urandom, edge_word()};
        default: begin
          s.coef_a = $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
          s.coef_b = $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
          s.coef_c = $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
        end
      endcase
      if ($urandom_range(0, 40) == 0) s.coef_a = '0;
      send_set(s);
    end
  endtask

  // one long run with the output never stalled
  task automatic test_no_stall();
    stall_free = 1'b1;
    burst_left = 200;
    test_random(200);
    stall_free = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    idle_until_drained();
    test_random(800);
    idle_until_drained();
    test_no_stall();
    test_random(800);
    idle_until_drained();
    $display("%0d coefficient sets sent, %0d results checked (%0d complex, %0d saturated)",
             sets_sent, results_seen, complex_seen, saturated_seen);
    if (mismatches == 0 && solutions_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/qrv_pkg.sv
rtl/core/qrv_div_pipe.sv
rtl/core/qrv_sqrt_pipe.sv
rtl/core/qrv_out_buf.sv
rtl/core/quadratic_root_and_vertex_solver_core.sv
tb/quadratic_root_and_vertex_solver_core_test.sv
